// ----- sv/see_pkg.sv -----
package see_pkg;

  localparam int WORD_W = 32;
  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  localparam logic [7:0] OP_PUSH_LEAF  = 8'd1;
  localparam logic [7:0] OP_LNOT       = 8'd2;
  localparam logic [7:0] OP_LOR        = 8'd3;
  localparam logic [7:0] OP_LAND       = 8'd4;
  localparam logic [7:0] OP_LNOR       = 8'd5;
  localparam logic [7:0] OP_NE_A       = 8'd6;
  localparam logic [7:0] OP_LNAND      = 8'd7;
  localparam logic [7:0] OP_EQ         = 8'd8;
  localparam logic [7:0] OP_NE_B       = 8'd9;
  localparam logic [7:0] OP_PUSH_VAL   = 8'd10;
  localparam logic [7:0] OP_PUSH_IMM   = 8'd11;
  localparam logic [7:0] OP_PUSH_POOL  = 8'd12;
  localparam logic [7:0] OP_GT         = 8'd13;
  localparam logic [7:0] OP_GE         = 8'd14;
  localparam logic [7:0] OP_LT         = 8'd15;
  localparam logic [7:0] OP_LE         = 8'd16;
  localparam logic [7:0] OP_ADD        = 8'd17;
  localparam logic [7:0] OP_SUB        = 8'd18;
  localparam logic [7:0] OP_MUL        = 8'd19;
  localparam logic [7:0] OP_DIV        = 8'd20;
  localparam logic [7:0] OP_MOD        = 8'd21;
  localparam logic [7:0] OP_NEG        = 8'd22;
  localparam logic [7:0] OP_HASH       = 8'd23;
  localparam logic [7:0] OP_HCOMB      = 8'd24;
  localparam logic [7:0] OP_AND        = 8'd25;
  localparam logic [7:0] OP_OR         = 8'd26;
  localparam logic [7:0] OP_XOR        = 8'd27;
  localparam logic [7:0] OP_INV        = 8'd28;

  // Operation class decoded from the opcode.
  localparam logic [1:0] CLS_PUSH  = 2'd0;
  localparam logic [1:0] CLS_UNARY = 2'd1;
  localparam logic [1:0] CLS_BIN   = 2'd2;
  localparam logic [1:0] CLS_BAD   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rd_issue;   // read top two stack entries
    logic       op_load;    // latch operands into the datapath
    logic       step;       // advance the multi-cycle unit one step
    logic       wb;         // write the result back to the stack
    logic       push;       // write the pushed value
  } see_cmd_t;

  typedef struct packed {
    logic        busy;      // multi-cycle unit still running
    logic        bad_div;   // divisor zero or overflow
  } see_sts_t;

  function automatic logic [1:0] op_class(input logic [7:0] op);
    case (op)
      OP_PUSH_LEAF, OP_PUSH_VAL, OP_PUSH_IMM, OP_PUSH_POOL: op_class = CLS_PUSH;
      OP_LNOT, OP_NEG, OP_HASH, OP_INV: op_class = CLS_UNARY;
      OP_LOR, OP_LAND, OP_LNOR, OP_NE_A, OP_LNAND, OP_EQ, OP_NE_B, OP_GT, OP_GE,
      OP_LT, OP_LE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_HCOMB, OP_AND,
      OP_OR, OP_XOR: op_class = CLS_BIN;
      default: op_class = CLS_BAD;
    endcase
  endfunction

endpackage

// ----- sv/see_if.sv -----
interface see_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [31:0] operand;
  logic signed [31:0] supplied_value;
  logic        supplied_ok;
  logic        last;
  modport source (output valid, opcode, operand, supplied_value, supplied_ok, last,
                  input ready);
  modport sink (input valid, opcode, operand, supplied_value, supplied_ok, last,
                output ready);
endinterface

interface see_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic signed [31:0] result;
  modport source (output valid, ok, result, input ready);
  modport sink (input valid, ok, result, output ready);
endinterface

// ----- sv/stack_expression_evaluator.sv -----
// Channel   Direction  Payload
// in_ch     input      opcode, operand, supplied_value, supplied_ok, last
// out_ch    output     ok, result (one per last instruction)
//
// Pushes and instructions rejected on acceptance finish in the idle state; the others
// pass through read, load, run or multiply, and write-back states; hashing runs one
// byte per step and signed divide or modulo one bit per step in a restoring divider.
// A result with ok set is held back by fix_r until the bottom entry has settled,
// a failed one is not; while any result waits on out_ch the input is held off.
// Reset is synchronous, active low; the stack array has no reset.
module stack_expression_evaluator
  import see_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int MAX_PROGRAM = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  see_in_if.sink    in_ch,
  see_out_if.source out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(MAX_PROGRAM + 2);

  see_cmd_t    cmd;
  see_sts_t    sts;
  logic [7:0]  op;
  logic [AW:0] depth;
  logic [31:0] push_val, bottom_val;

  see_ctrl #(.DEPTH(STACK_DEPTH), .AW(AW), .MAXP(MAX_PROGRAM), .CW(CW)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cmd, .sts, .op, .depth, .push_val, .bottom_val
  );

  see_datapath #(.DEPTH(STACK_DEPTH), .AW(AW)) u_dp (
    .clk, .rst_n, .cmd, .sts, .op, .depth, .push_val, .bottom_val
  );

endmodule

// ----- sv/see_datapath.sv -----
module see_datapath
  import see_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  see_cmd_t      cmd,
  output see_sts_t      sts,
  input  logic [7:0]    op,
  input  logic [AW:0]   depth,
  input  logic [31:0]   push_val,
  output logic [31:0]   bottom_val
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_a_r, rd_b_r;   // a = top, b = next below
  logic [31:0] bottom_r;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] opr_r, opr_nxt;   // right operand / divisor magnitude
  logic [31:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  op_r;
  logic [31:0] res;
  logic [AW-1:0] top_idx, nxt_idx, wb_idx;
  logic [32:0] diff;

  assign top_idx = AW'(depth - 1'b1);
  assign nxt_idx = AW'(depth - 2'd2);

  // Stack memory: one write and two reads per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth[AW-1:0]] <= push_val;
    end else if (cmd.wb) begin
      mem[wb_idx] <= res;
    end
    if (cmd.rd_issue) begin
      rd_a_r <= mem[top_idx];
      rd_b_r <= mem[nxt_idx];
    end
  end

  // Shadow of entry 0, the only one the final result reads.
  always_ff @(posedge clk) begin
    if (cmd.push && depth == '0) begin
      bottom_r <= push_val;
    end else if (cmd.wb && wb_idx == '0) begin
      bottom_r <= res;
    end
  end
  assign bottom_val = bottom_r;

  logic unary_op;
  assign unary_op = (op_class(op_r) == CLS_UNARY);
  assign wb_idx   = unary_op ? top_idx : nxt_idx;

  assign diff = {acc_r[31:0], quo_r[31]} - {1'b0, opr_r};

  // Sequenced unit: hashing consumes one byte per step; division one bit per step.
  always_comb begin
    acc_nxt   = acc_r;
    opr_nxt   = opr_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    bad_nxt   = bad_r;
    if (cmd.op_load) begin
      cnt_nxt = '0;
      bad_nxt = 1'b0;
      case (op)
        OP_DIV, OP_MOD: begin
          neg_q_nxt = rd_b_r[31] ^ rd_a_r[31];
          neg_r_nxt = rd_b_r[31];
          acc_nxt   = '0;
          quo_nxt   = rd_b_r[31] ? 32'(-rd_b_r) : rd_b_r;
          opr_nxt   = rd_a_r[31] ? 32'(-rd_a_r) : rd_a_r;
          cnt_nxt   = 6'd32;
          bad_nxt   = (rd_a_r == '0) ||
                      (rd_b_r == 32'h8000_0000 && rd_a_r == 32'hFFFF_FFFF);
        end
        OP_HASH: begin
          acc_nxt = FNV_BASIS;
          opr_nxt = rd_a_r;
          quo_nxt = rd_a_r;
          cnt_nxt = 6'd4;
        end
        OP_HCOMB: begin
          acc_nxt = rd_b_r;
          opr_nxt = rd_a_r;
          quo_nxt = rd_a_r;
          cnt_nxt = 6'd4;
        end
        OP_MUL: begin
          acc_nxt = rd_b_r;
          opr_nxt = rd_a_r;
        end
        default: begin
          // Unary opcodes take the top entry as their operand.
          acc_nxt = (op_class(op) == CLS_UNARY) ? rd_a_r : rd_b_r;
          opr_nxt = rd_a_r;
          quo_nxt = rd_a_r;
        end
      endcase
    end else if (cmd.step && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (op_r == OP_DIV || op_r == OP_MOD) begin
        if (!diff[32]) begin
          acc_nxt = diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end else begin
        acc_nxt = 32'((acc_r ^ {24'd0, quo_r[31:24]}) * FNV_PRIME);
        quo_nxt = {quo_r[23:0], 8'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
    end
    acc_r   <= acc_nxt;
    opr_r   <= opr_nxt;
    quo_r   <= quo_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    if (cmd.op_load) begin
      op_r <= op;
    end
  end

  logic [31:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= 32'(acc_r * opr_r);
  end

  logic signed [31:0] sx, sy;
  assign sx = acc_r;
  assign sy = opr_r;

  always_comb begin
    case (op_r)
      OP_LNOT:  res = {31'd0, acc_r == '0};
      OP_NEG:   res = 32'(-acc_r);
      OP_INV:   res = ~acc_r;
      OP_HASH, OP_HCOMB: res = acc_r;
      OP_LOR:   res = {31'd0, (acc_r != '0) || (opr_r != '0)};
      OP_LAND:  res = {31'd0, (acc_r != '0) && (opr_r != '0)};
      OP_LNOR:  res = {31'd0, !((acc_r != '0) || (opr_r != '0))};
      OP_LNAND: res = {31'd0, !((acc_r != '0) && (opr_r != '0))};
      OP_NE_A, OP_NE_B: res = {31'd0, acc_r != opr_r};
      OP_EQ:    res = {31'd0, acc_r == opr_r};
      OP_GT:    res = {31'd0, sx > sy};
      OP_GE:    res = {31'd0, sx >= sy};
      OP_LT:    res = {31'd0, sx < sy};
      OP_LE:    res = {31'd0, sx <= sy};
      OP_ADD:   res = acc_r + opr_r;
      OP_SUB:   res = acc_r - opr_r;
      OP_MUL:   res = prod_r;
      OP_DIV:   res = neg_q_r ? 32'(-quo_r) : quo_r;
      OP_MOD:   res = neg_r_r ? 32'(-acc_r) : acc_r;
      OP_AND:   res = acc_r & opr_r;
      OP_OR:    res = acc_r | opr_r;
      OP_XOR:   res = acc_r ^ opr_r;
      default:  res = acc_r;
    endcase
  end

  assign sts.busy    = (cnt_r != '0);
  assign sts.bad_div = bad_r;

`ifndef SYNTH
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op_load && (op == OP_DIV || op == OP_MOD) |=> cnt_r == 6'd32 || bad_r)
    else $error("divide did not start with a full count");
  a_no_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> cnt_r == '0)
    else $error("write-back while the unit is running");
  a_push_wb: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.wb))
    else $error("push and write-back in the same cycle");
`endif

endmodule

// ----- sv/see_ctrl.sv -----
module see_ctrl
  import see_pkg::*;
#(
  parameter int DEPTH   = 256,
  parameter int AW      = 8,
  parameter int MAXP    = 256,
  parameter int CW      = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  see_in_if.sink      in_ch,
  see_out_if.source   out_ch,
  output see_cmd_t    cmd,
  input  see_sts_t    sts,
  output logic [7:0]  op,
  output logic [AW:0] depth,
  output logic [31:0] push_val,
  input  logic [31:0] bottom_val
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] depth_r, depth_nxt;
  logic [CW:0] icnt_r, icnt_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  op_r;
  logic        last_r;
  logic        ovalid_r, ovalid_nxt, ook_r, ook_nxt;
  logic [31:0] ores_r, ores_nxt;
  logic        acc;
  logic        out_fire;
  logic [1:0]  cls;
  logic [CW:0] icnt_inc;
  logic        fail_now, done;
  logic [AW:0] depth_fin;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && (!ovalid_r || out_fire);
  assign acc = in_ch.valid && in_ch.ready;
  assign cls = op_class(in_ch.opcode);
  assign icnt_inc = (icnt_r <= (CW+1)'(MAXP)) ? icnt_r + 1'b1 : icnt_r;

  assign op       = (state_r == S_IDLE) ? in_ch.opcode : op_r;
  assign depth    = depth_r;
  assign push_val = (in_ch.opcode == OP_PUSH_IMM) ? in_ch.operand : in_ch.supplied_value;

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    icnt_nxt   = icnt_r;
    fail_nxt   = fail_r;
    cmd        = '0;
    done       = 1'b0;
    fail_now   = fail_r;
    depth_fin  = depth_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          icnt_nxt = icnt_inc;
          fail_now = fail_r || (icnt_inc > (CW+1)'(MAXP));
          if (!fail_now) begin
            case (cls)
              CLS_PUSH: begin
                if (depth_r >= (AW+1)'(DEPTH) ||
                    (in_ch.opcode == OP_PUSH_POOL && !in_ch.supplied_ok)) begin
                  fail_now = 1'b1;
                end else begin
                  cmd.push  = 1'b1;
                  depth_fin = depth_r + 1'b1;
                end
              end
              CLS_UNARY: begin
                if (depth_r == '0) fail_now = 1'b1;
                else state_nxt = S_READ;
              end
              CLS_BIN: begin
                if (depth_r < (AW+1)'(2)) fail_now = 1'b1;
                else state_nxt = S_READ;
              end
              default: fail_now = 1'b1;
            endcase
          end
          depth_nxt = depth_fin;
          fail_nxt  = fail_now;
          if (state_nxt == S_IDLE) done = in_ch.last;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op_load = 1'b1;
        state_nxt = (op_r == OP_MUL) ? S_MUL : S_RUN;
      end
      S_MUL: state_nxt = S_WB;
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.bad_div) begin
          fail_nxt  = 1'b1;
          fail_now  = 1'b1;
          state_nxt = S_IDLE;
          done      = last_r;
        end else if (!sts.busy) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (op_class(op_r) == CLS_BIN) depth_fin = depth_r - 1'b1;
        depth_nxt = depth_fin;
        state_nxt = S_IDLE;
        done      = last_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_fire;
    ook_nxt    = ook_r;
    ores_nxt   = ores_r;
    if (done) begin
      ovalid_nxt = 1'b1;
      ook_nxt    = !fail_now && depth_fin == (AW+1)'(1);
      ores_nxt   = '0;
    end
  end

  // A result computed by write-back lands in the bottom entry at this edge;
  // the output value is captured from it in the cycle after, when needed.
  logic fix_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      depth_r  <= '0;
      icnt_r   <= '0;
      fail_r   <= 1'b0;
      ovalid_r <= 1'b0;
      fix_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fix_r    <= 1'b0;
      ovalid_r <= ovalid_nxt;
      if (done) begin
        depth_r <= '0;
        icnt_r  <= '0;
        fail_r  <= 1'b0;
        fix_r   <= ook_nxt;
      end else begin
        depth_r <= depth_nxt;
        icnt_r  <= icnt_nxt;
        fail_r  <= fail_nxt;
      end
    end
    ook_r <= ook_nxt;
    if (fix_r) ores_r <= bottom_val;
    else       ores_r <= ores_nxt;
    if (acc) begin
      op_r   <= in_ch.opcode;
      last_r <= in_ch.last;
    end
  end

  // The output shows a valid beat only once its value has settled.
  assign out_ch.valid  = ovalid_r && !fix_r;
  assign out_ch.ok     = ook_r;
  assign out_ch.result = ook_r ? ores_r : '0;

`ifndef SYNTH
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= (AW+1)'(DEPTH))
    else $error("stack depth above capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE)
    else $error("input ready outside idle");
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> depth_r == '0 && !fail_r)
    else $error("program state not cleared after last");
`endif

endmodule

// ----- tb/stack_expression_evaluator_tb.sv -----
module stack_expression_evaluator_tb;
  import see_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] operand;
    logic [31:0] supplied_value;
    logic        supplied_ok;
    logic        last;
  } instr_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] result;
  } outcome_t;

  localparam int STK_MAX = 256;
  localparam int PROG_MAX = 256;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  see_in_if in_ch ();
  see_out_if out_ch ();

  stack_expression_evaluator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  instr_t pending_instrs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_sender = 0;
  int rx_hold = 0;
  bit in_busy = 0;
  int gap_cnt = 0;

  // Predictor state.
  logic [31:0] stk[STK_MAX];
  int depth = 0;
  int icount = 0;
  bit pfail = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] fnv4(logic [31:0] h, logic [31:0] v);
    for (int sh = 24; sh >= 0; sh -= 8) h = (h ^ ((v >> sh) & 32'hFF)) * FNV_PRIME;
    return h;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit run_instr(instr_t it);
    logic [31:0] l, r;
    logic signed [31:0] x, y;
    logic [7:0] op;
    op = it.opcode;
    if (op_class(op) == CLS_PUSH) begin
      if (depth >= STK_MAX) return 0;
      if (op == OP_PUSH_POOL && !it.supplied_ok) return 0;
      stk[depth] = (op == OP_PUSH_IMM) ? it.operand : it.supplied_value;
      depth++;
      return 1;
    end
    if (depth == 0) return 0;
    case (op)
      OP_LNOT: begin stk[depth-1] = (stk[depth-1] == 0); return 1; end
      OP_NEG:  begin stk[depth-1] = -stk[depth-1]; return 1; end
      OP_INV:  begin stk[depth-1] = ~stk[depth-1]; return 1; end
      OP_HASH: begin stk[depth-1] = fnv4(FNV_BASIS, stk[depth-1]); return 1; end
      default: ;
    endcase
    if (depth < 2) return 0;
    r = stk[depth-1];
    l = stk[depth-2];
    x = l;
    y = r;
    case (op)
      OP_LOR:   l = (l != 0 || r != 0);
      OP_LAND:  l = (l != 0 && r != 0);
      OP_LNOR:  l = !(l != 0 || r != 0);
      OP_NE_A, OP_NE_B: l = (l != r);
      OP_LNAND: l = !(l != 0 && r != 0);
      OP_EQ:    l = (l == r);
      OP_GT:    l = (x > y);
      OP_GE:    l = (x >= y);
      OP_LT:    l = (x < y);
      OP_LE:    l = (x <= y);
      OP_ADD:   l = l + r;
      OP_SUB:   l = l - r;
      OP_MUL:   l = l * r;
      OP_DIV, OP_MOD: begin
        if (y == 0 || (x == 32'sh80000000 && y == -1)) return 0;
        l = (op == OP_DIV) ? x / y : x % y;
      end
      OP_HCOMB: l = fnv4(l, r);
      OP_AND:   l = l & r;
      OP_OR:    l = l | r;
      OP_XOR:   l = l ^ r;
      default:  return 0;
    endcase
    depth--;
    stk[depth-1] = l;
    return 1;
  endfunction

  task automatic predict_outcome(instr_t it);
    outcome_t o;
    if (icount <= PROG_MAX) icount++;
    if (icount > PROG_MAX) pfail = 1;
    if (!pfail && !run_instr(it)) pfail = 1;
    if (it.last) begin
      o.ok = !pfail && depth == 1;
      o.result = o.ok ? stk[0] : 32'd0;
      expected_outcomes.push_back(o);
      depth = 0;
      icount = 0;
      pfail = 0;
    end
  endtask

  // Driver: offers queued items at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (!in_busy) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_ch.valid <= 0;
        end else if (pending_instrs.size() > 0 && !hold_sender) begin
          instr_t it;
          it = pending_instrs.pop_front();
          {in_ch.opcode, in_ch.operand, in_ch.supplied_value, in_ch.supplied_ok,
           in_ch.last} <= it;
          in_ch.valid <= 1;
          in_busy = 1;
          gap_cnt = gap_len();
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Predict on each accepted input transaction.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_outcome({in_ch.opcode, in_ch.operand, in_ch.supplied_value,
                       in_ch.supplied_ok, in_ch.last});
      in_busy = 0;
    end
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 3) rx_hold = $urandom_range(10, 60);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stack_expression_evaluator");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result ok=%0b result=%h", $realtime, out_ch.ok,
                 out_ch.result);
        errors++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (out_ch.ok !== e.ok) begin
          $display("%0t: ok expected %0b actual %0b", $realtime, e.ok, out_ch.ok);
          errors++;
        end
        if (out_ch.result !== e.result) begin
          $display("%0t: result expected %h actual %h", $realtime, e.result,
                   out_ch.result);
          errors++;
        end
      end
    end
  end

  function automatic instr_t mk(logic [7:0] op, logic [31:0] v, bit lst = 0);
    instr_t it;
    it.opcode = op;
    it.operand = v;
    it.supplied_value = v;
    it.supplied_ok = 1;
    it.last = lst;
    return it;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rnd_binop();
    logic [7:0] ops[20] = '{OP_LOR, OP_LAND, OP_LNOR, OP_NE_A, OP_LNAND, OP_EQ,
      OP_NE_B, OP_GT, OP_GE, OP_LT, OP_LE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_HCOMB, OP_AND, OP_OR, OP_XOR};
    return ops[$urandom_range(0, 19)];
  endfunction

  function automatic logic [7:0] rnd_unop();
    logic [7:0] ops[4] = '{OP_LNOT, OP_NEG, OP_HASH, OP_INV};
    return ops[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] rnd_push();
    logic [7:0] ops[4] = '{OP_PUSH_LEAF, OP_PUSH_VAL, OP_PUSH_IMM, OP_PUSH_POOL};
    return ops[$urandom_range(0, 3)];
  endfunction

  // Builds a well-formed program of 2*n items and closing binary operators, with noise mixed in only when noisy is set.
  task automatic gen_program(int n, bit noisy);
    instr_t it;
    int d;
    d = 0;
    for (int k = 0; k < 2 * n; k++) begin
      if (d < 1 || (d < 2 && k < n) || ($urandom_range(0, 2) == 0 && k < n)) begin
        it = mk(rnd_push(), rnd_word());
        it.operand = $urandom;
        if (noisy && $urandom_range(0, 15) == 0) it.supplied_ok = 0;
        d++;
      end else if ($urandom_range(0, 3) == 0) begin
        it = mk(rnd_unop(), $urandom);
      end else if (d >= 2) begin
        it = mk(rnd_binop(), $urandom);
        d--;
      end else begin
        it = mk(rnd_unop(), $urandom);
      end
      if (noisy && $urandom_range(0, 20) == 0) it.opcode = 8'($urandom);
      pending_instrs.push_back(it);
    end
    while (d > 1) begin
      pending_instrs.push_back(mk(rnd_binop(), $urandom));
      d--;
    end
    if (noisy && $urandom_range(0, 5) == 0) pending_instrs.push_back(mk(OP_PUSH_IMM, 7));
    pending_instrs[$].last = 1;
  endtask

  task automatic drain();
    while (pending_instrs.size() > 0 || in_busy || expected_outcomes.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    instr_t it;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.opcode = 0;
    in_ch.operand = 0;
    in_ch.supplied_value = 0;
    in_ch.supplied_ok = 0;
    in_ch.last = 0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, the faults other than stack full and program length, hashing, and divide corner cases.
    pending_instrs.push_back(mk(OP_PUSH_IMM, 32'h80000000));
    pending_instrs.push_back(mk(OP_PUSH_LEAF, 32'hFFFFFFFF));
    pending_instrs.push_back(mk(OP_DIV, 0, 1));
    pending_instrs.push_back(mk(OP_PUSH_VAL, 32'h7FFFFFFF));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 32'hFFFFFFF9));
    pending_instrs.push_back(mk(OP_MOD, 0, 1));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 5));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 0));
    pending_instrs.push_back(mk(OP_DIV, 0, 1));
    pending_instrs.push_back(mk(OP_HASH, 0, 1));
    pending_instrs.push_back(mk(OP_PUSH_LEAF, 1));
    pending_instrs.push_back(mk(OP_ADD, 0, 1));
    it = mk(OP_PUSH_POOL, 3, 1);
    it.supplied_ok = 0;
    pending_instrs.push_back(it);
    pending_instrs.push_back(mk(OP_PUSH_IMM, 32'hDEADBEEF));
    pending_instrs.push_back(mk(8'hFF, 0, 1));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 1));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 2, 1));
    pending_instrs.push_back(mk(OP_PUSH_IMM, 32'h12345678));
    pending_instrs.push_back(mk(OP_HASH, 0));
    pending_instrs.push_back(mk(OP_PUSH_POOL, 32'hA5A5A5A5));
    pending_instrs.push_back(mk(OP_HCOMB, 0));
    pending_instrs.push_back(mk(OP_NEG, 0));
    pending_instrs.push_back(mk(OP_INV, 0));
    pending_instrs.push_back(mk(OP_LNOT, 0, 1));
    drain();

    // Stack full: 257 pushes, which also runs past the program limit.
    for (int k = 0; k < STK_MAX + 1; k++) pending_instrs.push_back(mk(OP_PUSH_IMM, k));
    pending_instrs[$].last = 1;
    drain();

    // Receiver holds off while the sender keeps offering.
    rx_hold = 300;

    // Random programs; the sender pauses once until all results arrive.
    for (int p = 0; p < 30; p++) begin
      gen_program($urandom_range(1, 5), $urandom_range(0, 3) == 0);
      if (p == 15) begin
        drain();
        hold_sender = 1;
        repeat (50) @(posedge clk);
        hold_sender = 0;
      end
    end
    // Pure noise items.
    for (int k = 0; k < 40; k++) begin
      it.opcode = 8'($urandom_range(0, 31));
      it.operand = $urandom;
      it.supplied_value = $urandom;
      it.supplied_ok = 1'($urandom_range(0, 1));
      it.last = ($urandom_range(0, 4) == 0);
      pending_instrs.push_back(it);
    end
    pending_instrs[$].last = 1;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0)
      $display("PASS stack_expression_evaluator");
    else
      $display("FAIL stack_expression_evaluator");
    $finish;
  end
endmodule

// ----- stack_expression_evaluator.f -----
sv/see_pkg.sv
sv/see_if.sv
sv/see_datapath.sv
sv/see_ctrl.sv
sv/stack_expression_evaluator.sv
tb/stack_expression_evaluator_tb.sv
